[src/pcfe_pkg.sv]
package pcfe_pkg;

  // Field widths
  localparam int COORD_W  = 32;               // Q16.16 coordinates and charge
  localparam int ZR_W     = 31;               // zero radius
  localparam int MAG_W    = COORD_W + 1;      // |d| per axis
  localparam int SQ_W     = 2 * MAG_W;        // r^2, Q34.32
  localparam int ROOT_W   = SQ_W / 2;         // floor(sqrt(r^2)), Q17.16
  localparam int REM_W    = ROOT_W + 2;       // square-root partial remainder
  localparam int PROD_W   = 64;               // |Kq| * |d|
  localparam int DEN_W    = 3 * ROOT_W;       // R^3
  localparam int QUO_W    = 49;               // quotient bits kept
  // numerator p<<32: the division starts at quotient bit QUO_W-1,
  // so the first PROD_W+32-QUO_W numerator bits form the initial remainder
  localparam int PRE_W    = PROD_W + 32 - QUO_W;
  localparam int NBIT_W   = PROD_W - PRE_W;   // numerator bits fed during division
  localparam int FIELD_W  = 48;               // Q32.16 result
  localparam int CFG_IDX_W = 3;

  // Pipeline depth: front end, square root, cube, divide, output
  localparam int FRONT_STAGES = 3;
  localparam int SQRT_STAGES  = ROOT_W;
  localparam int CUBE_STAGES  = 4;
  localparam int DIV_STAGES   = QUO_W;
  localparam int PIPE_DEPTH   = FRONT_STAGES + SQRT_STAGES + CUBE_STAGES + DIV_STAGES + 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_X       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_Y       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_Z       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALED_CHARGE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_RADIUS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_AT_SOURCE = 3'd5;

  // Saturation limits on the quotient magnitude
  localparam logic [QUO_W-1:0] POS_LIMIT = QUO_W'(48'h7FFF_FFFF_FFFF);
  localparam logic [QUO_W-1:0] NEG_LIMIT = QUO_W'(48'h8000_0000_0000);

  // Data carried alongside the square root and the cube
  typedef struct packed {
    logic [2:0][PROD_W-1:0] p;
    logic [2:0]             dneg;
  } sb_t;

  // Flags carried alongside the dividers
  typedef struct packed {
    logic       coinc;
    logic [2:0] ovf;
    logic [2:0] neg;
  } div_sb_t;

endpackage

[src/pcfe_isqrt.sv]
// Pipelined integer square root, one result bit per stage
module pcfe_isqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [pcfe_pkg::SQ_W-1:0]     r2,
  output logic [pcfe_pkg::ROOT_W-1:0]   root
);

  localparam int N = pcfe_pkg::SQRT_STAGES;

  logic [pcfe_pkg::REM_W-1:0]  rem_q  [0:N-1];
  logic [pcfe_pkg::ROOT_W-1:0] root_q [0:N-1];
  logic [pcfe_pkg::SQ_W-1:0]   rest_q [0:N-1];

  logic [pcfe_pkg::REM_W-1:0]  rem_in  [0:N-1];
  logic [pcfe_pkg::ROOT_W-1:0] root_in [0:N-1];
  logic [pcfe_pkg::SQ_W-1:0]   rest_in [0:N-1];
  logic [pcfe_pkg::REM_W+1:0]  cur     [0:N-1];
  logic [pcfe_pkg::REM_W+1:0]  trial   [0:N-1];
  logic                        ge      [0:N-1];

  // per stage: bring down two bits, try root*4+1
  always_comb begin
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        rem_in[k]  = '0;
        root_in[k] = '0;
        rest_in[k] = r2;
      end else begin
        rem_in[k]  = rem_q[k-1];
        root_in[k] = root_q[k-1];
        rest_in[k] = rest_q[k-1];
      end
      cur[k]   = {rem_in[k], rest_in[k][pcfe_pkg::SQ_W-1 -: 2]};
      trial[k] = {2'b00, root_in[k], 2'b01};
      ge[k]    = cur[k] >= trial[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        if (ge[k]) begin
          rem_q[k]  <= pcfe_pkg::REM_W'(cur[k] - trial[k]);
          root_q[k] <= {root_in[k][pcfe_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem_q[k]  <= pcfe_pkg::REM_W'(cur[k]);
          root_q[k] <= {root_in[k][pcfe_pkg::ROOT_W-2:0], 1'b0};
        end
        rest_q[k] <= {rest_in[k][pcfe_pkg::SQ_W-3:0], 2'b00};
      end
    end
  end

  assign root = root_q[N-1];

endmodule

[src/pcfe_div.sv]
// Pipelined restoring divider, one quotient bit per stage
module pcfe_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [pcfe_pkg::DEN_W-1:0]    rem0,
  input  logic [pcfe_pkg::NBIT_W-1:0]   bits,
  input  logic [pcfe_pkg::DEN_W-1:0]    den,
  output logic [pcfe_pkg::QUO_W-1:0]    quo
);

  localparam int N = pcfe_pkg::DIV_STAGES;

  logic [pcfe_pkg::DEN_W-1:0]  rem_q  [0:N-1];
  logic [pcfe_pkg::DEN_W-1:0]  den_q  [0:N-1];
  logic [pcfe_pkg::NBIT_W-1:0] bits_q [0:N-1];
  logic [pcfe_pkg::QUO_W-1:0]  quo_q  [0:N-1];

  logic [pcfe_pkg::DEN_W-1:0]  rem_in  [0:N-1];
  logic [pcfe_pkg::DEN_W-1:0]  den_in  [0:N-1];
  logic [pcfe_pkg::NBIT_W-1:0] bits_in [0:N-1];
  logic [pcfe_pkg::QUO_W-1:0]  quo_in  [0:N-1];
  logic [pcfe_pkg::DEN_W:0]    cur     [0:N-1];
  logic                        ge      [0:N-1];

  // shift in the next numerator bit, subtract where it fits
  always_comb begin
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        rem_in[k]  = rem0;
        den_in[k]  = den;
        bits_in[k] = bits;
        quo_in[k]  = '0;
      end else begin
        rem_in[k]  = rem_q[k-1];
        den_in[k]  = den_q[k-1];
        bits_in[k] = bits_q[k-1];
        quo_in[k]  = quo_q[k-1];
      end
      cur[k] = {rem_in[k], bits_in[k][pcfe_pkg::NBIT_W-1]};
      ge[k]  = cur[k] >= {1'b0, den_in[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        if (ge[k]) begin
          rem_q[k] <= pcfe_pkg::DEN_W'(cur[k] - {1'b0, den_in[k]});
        end else begin
          rem_q[k] <= pcfe_pkg::DEN_W'(cur[k]);
        end
        quo_q[k]  <= {quo_in[k][pcfe_pkg::QUO_W-2:0], ge[k]};
        den_q[k]  <= den_in[k];
        bits_q[k] <= {bits_in[k][pcfe_pkg::NBIT_W-2:0], 1'b0};
      end
    end
  end

  assign quo = quo_q[N-1];

endmodule

[src/point_charge_field_evaluator.sv]
// Channel   Direction  Transaction
// s_*       in         one query point (x, y, z)
// m_*       out        one field vector plus coincident and saturated flags
// cfg_*     in         one register write (index, data)
//
// One point is accepted every cycle unless m_tready stalls the pipeline; each result
// leaves after 90 register stages, which include the 33-stage square root and the
// 49-stage divider (one bit each).
// rst clears the valid bits and the configuration registers to their reset values.
// A stall on m_tready freezes the whole pipeline; s_tready follows it.
module point_charge_field_evaluator (
  input  logic          clk,
  input  logic          rst,
  // point_x, point_y, point_z
  input  logic [95:0]   s_tdata,
  input  logic          s_tvalid,
  output logic          s_tready,
  // field_x, field_y, field_z
  output logic [143:0]  m_tdata,
  // coincident, saturated
  output logic [1:0]    m_tuser,
  output logic          m_tvalid,
  input  logic          m_tready,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [pcfe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]   cfg_data
);

  localparam int CW = pcfe_pkg::COORD_W;
  localparam int MW = pcfe_pkg::MAG_W;
  localparam int RW = pcfe_pkg::ROOT_W;
  localparam int DW = pcfe_pkg::DEN_W;
  localparam int PW = pcfe_pkg::PROD_W;
  localparam int NS = pcfe_pkg::PIPE_DEPTH;
  localparam int SQN = pcfe_pkg::SQRT_STAGES;
  localparam int DVN = pcfe_pkg::DIV_STAGES;

  // Configuration registers
  logic [CW-1:0] source_x, source_y, source_z, scaled_charge;
  logic [pcfe_pkg::ZR_W-1:0] zero_radius;
  logic zero_at_source;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_x       <= '0;
      source_y       <= '0;
      source_z       <= '0;
      scaled_charge  <= '0;
      zero_radius    <= pcfe_pkg::ZR_W'(1);
      zero_at_source <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pcfe_pkg::REG_SOURCE_X:       source_x       <= cfg_data;
        pcfe_pkg::REG_SOURCE_Y:       source_y       <= cfg_data;
        pcfe_pkg::REG_SOURCE_Z:       source_z       <= cfg_data;
        pcfe_pkg::REG_SCALED_CHARGE:  scaled_charge  <= cfg_data;
        pcfe_pkg::REG_ZERO_RADIUS:    zero_radius    <= cfg_data[pcfe_pkg::ZR_W-1:0];
        pcfe_pkg::REG_ZERO_AT_SOURCE: zero_at_source <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Global pipeline enable and valid bits
  logic [NS-1:0] vld;
  logic en;

  assign en       = ~vld[NS-1] | m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], s_tvalid};
    end
  end

  // |Kq| and its sign
  logic [CW-1:0] qa;
  logic qneg;
  assign qneg = scaled_charge[CW-1];
  assign qa   = qneg ? CW'(-scaled_charge) : scaled_charge;

  // Stage 1: offsets from the source
  logic [2:0][CW-1:0] pt, src;
  logic signed [MW-1:0] d [0:2];
  logic [2:0][MW-1:0] s1_a;
  logic [2:0] s1_dneg;

  assign pt  = {s_tdata[95:64], s_tdata[63:32], s_tdata[31:0]};
  assign src = {source_z, source_y, source_x};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d[i] = $signed({pt[i][CW-1], pt[i]}) - $signed({src[i][CW-1], src[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_a[i]    <= d[i][MW-1] ? MW'(-d[i]) : MW'(d[i]);
        s1_dneg[i] <= d[i][MW-1];
      end
    end
  end

  // Stage 2: squares and charge products
  logic [2:0][pcfe_pkg::SQ_W-1:0] s2_sq;
  logic [2:0][PW-1:0] s2_p;
  logic [2:0] s2_dneg;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s2_sq[i] <= s1_a[i] * s1_a[i];
        s2_p[i]  <= PW'({{MW{1'b0}}, qa} * {{CW{1'b0}}, s1_a[i]});
      end
      s2_dneg <= s1_dneg;
    end
  end

  // Stage 3: r^2
  logic [pcfe_pkg::SQ_W-1:0] s3_r2;
  pcfe_pkg::sb_t s3_sb;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r2      <= s2_sq[0] + s2_sq[1] + s2_sq[2];
      s3_sb.p    <= s2_p;
      s3_sb.dneg <= s2_dneg;
    end
  end

  // Square root, with the side data delayed to match
  logic [RW-1:0] root;
  pcfe_pkg::sb_t sbd [0:SQN-1];

  pcfe_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .r2   (s3_r2),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sbd[0] <= s3_sb;
      for (int k = 1; k < SQN; k++) begin
        sbd[k] <= sbd[k-1];
      end
    end
  end

  // Cube stage 1: R^2 and the forced-zero test
  logic [pcfe_pkg::SQ_W-1:0] m1_sq;
  logic [RW-1:0] m1_root;
  logic m1_coinc;
  pcfe_pkg::sb_t m1_sb;

  always_ff @(posedge clk) begin
    if (en) begin
      m1_sq    <= root * root;
      m1_root  <= root;
      m1_coinc <= (root == '0) ||
                  (zero_at_source && (root < {{(RW - pcfe_pkg::ZR_W){1'b0}}, zero_radius}));
      m1_sb    <= sbd[SQN-1];
    end
  end

  // Cube stage 2: two half products of R^2 * R
  logic [pcfe_pkg::SQ_W-1:0] m2_lo, m2_hi;
  logic m2_coinc;
  pcfe_pkg::sb_t m2_sb;

  always_ff @(posedge clk) begin
    if (en) begin
      m2_lo    <= m1_sq[RW-1:0] * m1_root;
      m2_hi    <= m1_sq[2*RW-1:RW] * m1_root;
      m2_coinc <= m1_coinc;
      m2_sb    <= m1_sb;
    end
  end

  // Cube stage 3: R^3
  logic [DW-1:0] m3_den;
  logic m3_coinc;
  pcfe_pkg::sb_t m3_sb;

  always_ff @(posedge clk) begin
    if (en) begin
      m3_den   <= {{RW{1'b0}}, m2_lo} + {m2_hi, {RW{1'b0}}};
      m3_coinc <= m2_coinc;
      m3_sb    <= m2_sb;
    end
  end

  // Cube stage 4: initial remainders and quotient overflow check
  logic [DW-1:0] m4_den;
  logic [2:0][pcfe_pkg::PRE_W-1:0] m4_pre;
  logic [2:0][pcfe_pkg::NBIT_W-1:0] m4_bits;
  pcfe_pkg::div_sb_t m4_sb;

  always_ff @(posedge clk) begin
    if (en) begin
      m4_den      <= m3_den;
      m4_sb.coinc <= m3_coinc;
      for (int i = 0; i < 3; i++) begin
        m4_pre[i]    <= m3_sb.p[i][PW-1:pcfe_pkg::NBIT_W];
        m4_bits[i]   <= m3_sb.p[i][pcfe_pkg::NBIT_W-1:0];
        m4_sb.ovf[i] <= DW'(m3_sb.p[i][PW-1:pcfe_pkg::NBIT_W]) >= m3_den;
        m4_sb.neg[i] <= qneg ^ m3_sb.dneg[i];
      end
    end
  end

  // Dividers, one per axis
  logic [2:0][pcfe_pkg::QUO_W-1:0] quo;
  pcfe_pkg::div_sb_t dsb [0:DVN-1];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    pcfe_div u_div (
      .clk  (clk),
      .en   (en),
      .rem0 (DW'(m4_pre[i])),
      .bits (m4_bits[i]),
      .den  (m4_den),
      .quo  (quo[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dsb[0] <= m4_sb;
      for (int k = 1; k < DVN; k++) begin
        dsb[k] <= dsb[k-1];
      end
    end
  end

  // Sign, saturation and output register
  logic [2:0][pcfe_pkg::FIELD_W-1:0] fv;
  logic [2:0] clip;
  logic [2:0][pcfe_pkg::FIELD_W-1:0] field;
  logic coinc_o, sat_o;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dsb[DVN-1].neg[i]) begin
        clip[i] = dsb[DVN-1].ovf[i] || (quo[i] > pcfe_pkg::NEG_LIMIT);
        fv[i]   = clip[i] ? pcfe_pkg::FIELD_W'(pcfe_pkg::NEG_LIMIT)
                          : pcfe_pkg::FIELD_W'(-quo[i]);
      end else begin
        clip[i] = dsb[DVN-1].ovf[i] || (quo[i] > pcfe_pkg::POS_LIMIT);
        fv[i]   = clip[i] ? pcfe_pkg::FIELD_W'(pcfe_pkg::POS_LIMIT)
                          : pcfe_pkg::FIELD_W'(quo[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      coinc_o <= dsb[DVN-1].coinc;
      if (dsb[DVN-1].coinc) begin
        field <= '0;
        sat_o <= 1'b0;
      end else begin
        field <= fv;
        sat_o <= |clip;
      end
    end
  end

  assign m_tdata = field;
  assign m_tuser = {sat_o, coinc_o};

endmodule
